[src/isfp_pkg.sv]
// Shared constants for the serial frame parser.
package isfp_pkg;

	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_ACCEL = 8'h51;
	localparam logic [7:0] TYPE_RATE  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam logic [7:0] TYPE_FIELD = 8'h54;

	localparam int unsigned CNT_W = 4;
	localparam logic [CNT_W-1:0] CNT_HUNT  = 4'd0;
	localparam logic [CNT_W-1:0] CNT_TYPE  = 4'd1;
	localparam logic [CNT_W-1:0] CNT_CHECK = 4'd10;

	typedef logic signed [15:0] word_t;
	typedef word_t vec3_t [3];

endpackage

[src/imu_serial_frame_parser.sv]
// Byte-serial parser for 11-byte sum-checked sensor frames, snapshot on angle frames.
// An accepted byte is held in the byte stage and then parsed; an angle frame's check byte loads the snapshot.
// Throughput: one byte per cycle; the byte stage stalls only while a finished snapshot
// waits and the staged byte would produce another.
// Reset (arst_n low, asynchronous): hunts for a header, held values zero, no snapshot.
// Checksum is kept as a running sum, so each byte costs one 8-bit add and one compare.
module imu_serial_frame_parser
	import isfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] accel_x,
	output logic signed [15:0] accel_y,
	output logic signed [15:0] accel_z,
	output logic signed [15:0] rate_x,
	output logic signed [15:0] rate_y,
	output logic signed [15:0] rate_z,
	output logic signed [15:0] angle_x,
	output logic signed [15:0] angle_y,
	output logic signed [15:0] angle_z,
	output logic signed [15:0] field_x,
	output logic signed [15:0] field_y,
	output logic signed [15:0] field_z
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parse state
	logic [CNT_W-1:0] count_q;
	logic [7:0]       sum_q;
	logic [7:0]       type_q;
	logic [7:0]       data_q [6];
	vec3_t            accel_q, rate_q, angle_q, field_q;

	// result register
	logic  out_valid_q;
	vec3_t o_accel_q, o_rate_q, o_angle_q, o_field_q;

	logic  frame_ok;
	logic  emit;
	logic  go;
	vec3_t words;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			words[i] = word_t'({data_q[2*i+1], data_q[2*i]});
		end
	end

	assign frame_ok = (count_q == CNT_CHECK) && (sum_q == byte_s1) &&
		(type_q == TYPE_ACCEL || type_q == TYPE_RATE ||
		 type_q == TYPE_ANGLE || type_q == TYPE_FIELD);
	assign emit     = valid_s1 && frame_ok && (type_q == TYPE_ANGLE);
	assign go       = valid_s1 && !(emit && out_valid_q && !out_ready);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_HUNT;
			for (int i = 0; i < 3; i++) begin
				accel_q[i] <= '0;
				rate_q[i]  <= '0;
				angle_q[i] <= '0;
				field_q[i] <= '0;
			end
		end else if (go) begin
			if (count_q == CNT_HUNT) begin
				if (byte_s1 == HDR_BYTE) begin
					count_q <= CNT_TYPE;
				end
			end else if (count_q == CNT_CHECK) begin
				count_q <= CNT_HUNT;
				if (frame_ok) begin
					case (type_q)
						TYPE_ACCEL: accel_q <= words;
						TYPE_RATE:  rate_q  <= words;
						TYPE_ANGLE: angle_q <= words;
						default:    field_q <= words;
					endcase
				end
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// frame payload: running sum, type byte, first six data bytes
	always_ff @(posedge clk) begin
		if (go) begin
			if (count_q == CNT_HUNT) begin
				sum_q <= byte_s1;
			end else begin
				sum_q <= sum_q + byte_s1;
			end
			if (count_q == CNT_TYPE) begin
				type_q <= byte_s1;
			end
			case (count_q)
				4'd2:    data_q[0] <= byte_s1;
				4'd3:    data_q[1] <= byte_s1;
				4'd4:    data_q[2] <= byte_s1;
				4'd5:    data_q[3] <= byte_s1;
				4'd6:    data_q[4] <= byte_s1;
				4'd7:    data_q[5] <= byte_s1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// snapshot: angle comes from the frame just finished
	always_ff @(posedge clk) begin
		if (go && emit) begin
			o_accel_q <= accel_q;
			o_rate_q  <= rate_q;
			o_angle_q <= words;
			o_field_q <= field_q;
		end
	end

	assign out_valid = out_valid_q;
	assign accel_x   = o_accel_q[0];
	assign accel_y   = o_accel_q[1];
	assign accel_z   = o_accel_q[2];
	assign rate_x    = o_rate_q[0];
	assign rate_y    = o_rate_q[1];
	assign rate_z    = o_rate_q[2];
	assign angle_x   = o_angle_q[0];
	assign angle_y   = o_angle_q[1];
	assign angle_z   = o_angle_q[2];
	assign field_x   = o_field_q[0];
	assign field_y   = o_field_q[1];
	assign field_z   = o_field_q[2];

endmodule
